// ===== sv/yrcc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrcc_pkg: shared constants for the YUYV / RGB24 color space converter
// Fixed-point coefficient helper, register map and defaults.
// ----------------------------------------------------------------------------
package yrcc_pkg;

  // default number of fraction bits in the coefficients
  localparam int COEF_FRAC_DEF = 16;

  // register byte addresses
  localparam logic [2:0] REG_DIRECTION = 3'd0;

  // direction codes
  localparam logic MODE_YUYV_TO_RGB = 1'b0;
  localparam logic MODE_RGB_TO_YUYV = 1'b1;

  localparam longint MICRO = 64'sd1000000;
  localparam longint HALF_MICRO = 64'sd500000;

  // coefficient given in millionths, rounded half up to frac fraction bits
  function automatic longint coef(input longint micro, input int frac);
    return ((micro <<< frac) + HALF_MICRO) / MICRO;
  endfunction

endpackage

// ===== sv/yuyv_rgb24_colorspace_convert_core.sv =====
// ----------------------------------------------------------------------------
// yuyv_rgb24_colorspace_convert_core: BT.601 pixel-pair converter
// Converts YUYV quads to RGB24 pixel pairs or back, direction set by register.
// ----------------------------------------------------------------------------
// Usage:
//   One pixel pair per request on the s_axis stream, one result per request on
//   the m_axis stream, in order. Mode 0 takes Y0 U Y1 V in bytes 0..3 and
//   returns R0 G0 B0 R1 G1 B1; mode 1 takes R0 G0 B0 R1 G1 B1 and returns
//   Y0 U Y1 V 0 0 with U and V averaged over the pair.
//   The direction register sits at APB address 0 (bit 0); write it only when
//   the stream is drained.
//   From input accept to output valid there are four register stages (input
//   register, multiplier stage, sum stage, clip/output register), the first
//   loaded at the accepting edge. Throughput is one pixel pair per clock while
//   m_axis is not stalled; the multiplier stage sets the cycle time.
//   A stall on m_axis freezes the whole pipeline and drops s_axis_tready in
//   the same cycle; nothing is lost or repeated. Bubbles are not squeezed out.
//   Reset clears all valid flags and sets the direction to YUYV to RGB.
// ----------------------------------------------------------------------------
module yuyv_rgb24_colorspace_convert_core #(
  parameter int COEF_FRAC = yrcc_pkg::COEF_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // in_byte0 .. in_byte5, 8 bits each, low first
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_byte0 .. out_byte5, 8 bits each, low first
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = COEF_FRAC + 2;   // signed coefficient, all below 2.0
  localparam int PW = CW + 9;          // coefficient times centered byte
  localparam int SW = COEF_FRAC + 12;  // sums, chroma pair total included

  localparam logic signed [CW-1:0] K_RV = CW'(yrcc_pkg::coef(64'sd1402000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_GU = CW'(yrcc_pkg::coef(64'sd344140, COEF_FRAC));
  localparam logic signed [CW-1:0] K_GV = CW'(yrcc_pkg::coef(64'sd714140, COEF_FRAC));
  localparam logic signed [CW-1:0] K_BU = CW'(yrcc_pkg::coef(64'sd1772000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_YR = CW'(yrcc_pkg::coef(64'sd299000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_YG = CW'(yrcc_pkg::coef(64'sd587000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_YB = CW'(yrcc_pkg::coef(64'sd114000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_UR = CW'(yrcc_pkg::coef(64'sd147000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_UG = CW'(yrcc_pkg::coef(64'sd289000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_UB = CW'(yrcc_pkg::coef(64'sd436000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_VR = CW'(yrcc_pkg::coef(64'sd615000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_VG = CW'(yrcc_pkg::coef(64'sd515000, COEF_FRAC));
  localparam logic signed [CW-1:0] K_VB = CW'(yrcc_pkg::coef(64'sd100000, COEF_FRAC));

  // +128 offset in sum units
  localparam logic signed [SW-1:0] OFS = SW'(64'sd128 <<< COEF_FRAC);

  // negative gives 0, else truncate and saturate at 255
  function automatic logic [7:0] clip_sum(input logic signed [SW-1:0] s);
    if (s[SW-1]) begin
      return 8'd0;
    end else if (|s[SW-2:COEF_FRAC+8]) begin
      return 8'hFF;
    end else begin
      return s[COEF_FRAC+7:COEF_FRAC];
    end
  endfunction

  // ---------------- configuration ----------------
  logic mode;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= yrcc_pkg::MODE_YUYV_TO_RGB;
    end else if (cfg_wr && paddr[2] == yrcc_pkg::REG_DIRECTION[2]) begin
      mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == yrcc_pkg::REG_DIRECTION[2]) begin
      prdata[0] = mode;
    end
  end

  // ---------------- pipeline control ----------------
  logic advance;
  logic v1, v2, v3;

  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      v1            <= s_axis_tvalid;
      v2            <= v1;
      v3            <= v2;
      m_axis_tvalid <= v3;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [7:0] s1_byte [6];
  logic       s1_mode;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 6; i++) begin
        s1_byte[i] <= s_axis_tdata[8*i +: 8];
      end
      s1_mode <= mode;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [8:0] d [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d[i] = $signed({1'b0, s1_byte[i]}) - 9'sd128;
    end
  end

  logic signed [PW-1:0] p_rv, p_gu, p_gv, p_bu;
  logic signed [PW-1:0] p_y [2][3];
  logic signed [PW-1:0] p_u [2][3];
  logic signed [PW-1:0] p_v [2][3];
  logic [7:0]           s2_y0, s2_y1;
  logic                 s2_mode;

  always_ff @(posedge clk) begin
    if (advance) begin
      p_rv <= PW'(K_RV) * PW'(d[3]);
      p_gu <= PW'(K_GU) * PW'(d[1]);
      p_gv <= PW'(K_GV) * PW'(d[3]);
      p_bu <= PW'(K_BU) * PW'(d[1]);
      for (int p = 0; p < 2; p++) begin
        p_y[p][0] <= PW'(K_YR) * PW'(d[3*p]);
        p_y[p][1] <= PW'(K_YG) * PW'(d[3*p+1]);
        p_y[p][2] <= PW'(K_YB) * PW'(d[3*p+2]);
        p_u[p][0] <= PW'(K_UR) * PW'(d[3*p]);
        p_u[p][1] <= PW'(K_UG) * PW'(d[3*p+1]);
        p_u[p][2] <= PW'(K_UB) * PW'(d[3*p+2]);
        p_v[p][0] <= PW'(K_VR) * PW'(d[3*p]);
        p_v[p][1] <= PW'(K_VG) * PW'(d[3*p+1]);
        p_v[p][2] <= PW'(K_VB) * PW'(d[3*p+2]);
      end
      s2_y0   <= s1_byte[0];
      s2_y1   <= s1_byte[2];
      s2_mode <= s1_mode;
    end
  end

  // ---------------- stage 3: per-pixel sums ----------------
  logic signed [SW-1:0] y0e, y1e;
  logic signed [SW-1:0] sum_next [6];
  logic signed [SW-1:0] s3_sum [6];
  logic                 s3_mode;

  assign y0e = $signed(SW'({s2_y0, {COEF_FRAC{1'b0}}}));
  assign y1e = $signed(SW'({s2_y1, {COEF_FRAC{1'b0}}}));

  always_comb begin
    if (s2_mode == yrcc_pkg::MODE_YUYV_TO_RGB) begin
      sum_next[0] = y0e + SW'(p_rv);
      sum_next[1] = y0e - SW'(p_gu) - SW'(p_gv);
      sum_next[2] = y0e + SW'(p_bu);
      sum_next[3] = y1e + SW'(p_rv);
      sum_next[4] = y1e - SW'(p_gu) - SW'(p_gv);
      sum_next[5] = y1e + SW'(p_bu);
    end else begin
      // luma0, u0, luma1, v0, u1, v1; chroma pairs are added in stage 4
      sum_next[0] = SW'(p_y[0][0]) + SW'(p_y[0][1]) + SW'(p_y[0][2]) + OFS;
      sum_next[1] = SW'(p_u[0][2]) - SW'(p_u[0][0]) - SW'(p_u[0][1]) + OFS;
      sum_next[2] = SW'(p_y[1][0]) + SW'(p_y[1][1]) + SW'(p_y[1][2]) + OFS;
      sum_next[3] = SW'(p_v[0][0]) - SW'(p_v[0][1]) - SW'(p_v[0][2]) + OFS;
      sum_next[4] = SW'(p_u[1][2]) - SW'(p_u[1][0]) - SW'(p_u[1][1]) + OFS;
      sum_next[5] = SW'(p_v[1][0]) - SW'(p_v[1][1]) - SW'(p_v[1][2]) + OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 6; i++) begin
        s3_sum[i] <= sum_next[i];
      end
      s3_mode <= s2_mode;
    end
  end

  // ---------------- stage 4: clip and output register ----------------
  logic signed [SW-1:0] cu_sum, cv_sum;
  logic [47:0]          out_next;
  logic                 out_mode;

  assign cu_sum = s3_sum[1] + s3_sum[4];
  assign cv_sum = s3_sum[3] + s3_sum[5];

  always_comb begin
    if (s3_mode == yrcc_pkg::MODE_YUYV_TO_RGB) begin
      for (int i = 0; i < 6; i++) begin
        out_next[8*i +: 8] = clip_sum(s3_sum[i]);
      end
    end else begin
      // pair average: one extra bit of shift
      out_next[7:0]   = clip_sum(s3_sum[0]);
      out_next[15:8]  = clip_sum(cu_sum >>> 1);
      out_next[23:16] = clip_sum(s3_sum[2]);
      out_next[31:24] = clip_sum(cv_sum >>> 1);
      out_next[47:32] = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= out_next;
      out_mode     <= s3_mode;
    end
  end

  // ---------------- assertions ----------------
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted request did not enter stage 1");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_stage3_drains : assert property (@(posedge clk) disable iff (rst)
    v3 && advance |=> m_axis_tvalid)
    else $error("stage 3 request lost on its way to the output");

  a_rgb_to_yuyv_pad : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_mode == yrcc_pkg::MODE_RGB_TO_YUYV |-> m_axis_tdata[47:32] == 16'd0)
    else $error("unused output bytes not zero in RGB to YUYV mode");

endmodule
